### design/lle_pkg.sv
// Shared types, codes and sizes for the location list entry parser.
// No dependencies; every other design file imports this package.
package lle_pkg;

  // Sizes
  localparam int EXPR_BYTES   = 32;
  localparam int EXPR_AW      = $clog2(EXPR_BYTES);
  localparam int ADDR_ENTRIES = 256;
  localparam int ADDR_AW      = $clog2(ADDR_ENTRIES);
  localparam int QDEPTH       = 2;
  localparam int QAW          = $clog2(QDEPTH);
  localparam int QCW          = $clog2(QDEPTH + 1);

  // Input actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_LOAD  = 2'd2;

  // Result kinds
  localparam logic [2:0] RK_ENTRY = 3'd0;
  localparam logic [2:0] RK_EXPR  = 3'd1;
  localparam logic [2:0] RK_END   = 3'd2;
  localparam logic [2:0] RK_SECT  = 3'd3;
  localparam logic [2:0] RK_TRUNC = 3'd4;
  localparam logic [2:0] RK_ERR   = 3'd5;

  // Entry codes
  localparam logic [3:0] EK_END_OF_LIST   = 4'd0;
  localparam logic [3:0] EK_BASE_ADDRX    = 4'd1;
  localparam logic [3:0] EK_STARTX_ENDX   = 4'd2;
  localparam logic [3:0] EK_STARTX_LENGTH = 4'd3;
  localparam logic [3:0] EK_OFFSET_PAIR   = 4'd4;
  localparam logic [3:0] EK_DEFAULT_LOC   = 4'd5;
  localparam logic [3:0] EK_BASE_ADDR     = 4'd6;
  localparam logic [3:0] EK_START_END     = 4'd7;
  localparam logic [3:0] EK_START_LENGTH  = 4'd8;

  // Configuration register indexes
  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_ABYTES = 2'd1;
  localparam logic [1:0] REG_SBYTES = 2'd2;
  localparam logic [1:0] REG_TCOUNT = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        section_last;
    logic [7:0]  table_index;
    logic [63:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  entry_kind;
    logic [63:0] range_start;
    logic [63:0] range_end;
    logic        is_default;
    logic [5:0]  expr_length;
    logic [7:0]  expr_byte;
    logic        run_last;
  } out_item_t;

  typedef struct packed {
    logic [63:0] initial_base;
    logic [7:0]  address_bytes;
    logic [7:0]  selector_bytes;
    logic [8:0]  table_count;
  } cfg_t;

  // One queued job: optional record with its expression, optional closing result
  typedef struct packed {
    logic        has_rec;
    logic [3:0]  entry_kind;
    logic [63:0] range_start;
    logic [63:0] range_end;
    logic        is_default;
    logic [5:0]  expr_length;
    logic        tail_valid;
    logic [2:0]  tail_kind;
  } job_t;

  // Expression buffer write port
  typedef struct packed {
    logic               en;
    logic [EXPR_AW-1:0] addr;
    logic [7:0]         data;
  } bw_t;

endpackage

### design/lle_queue.sv
// Short job queue between the parser front and the result back end.
// Depends on lle_pkg for the job type and depth.
module lle_queue import lle_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  input  logic pop,
  output job_t dout,
  output logic full,
  output logic empty
);

  job_t             slot_r [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt;
  logic [QAW-1:0]   rp_r, rp_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCW'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = slot_r[rp_r];

  // Pointer and count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QAW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == QAW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= din;
    end
  end

endmodule

### design/lle_front.sv
// Parser front: accepts items, decodes entry fields, owns the address table
// and issues jobs. Depends on lle_pkg.
module lle_front import lle_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     q_full,
  input  logic     back_quiet,
  output logic     push,
  output job_t     job,
  output bw_t      bw,
  output logic     lk_pend
);

  localparam logic [2:0] PH_CODE = 3'd0;
  localparam logic [2:0] PH_LEB  = 3'd1;
  localparam logic [2:0] PH_SEL  = 3'd2;
  localparam logic [2:0] PH_ADDR = 3'd3;
  localparam logic [2:0] PH_EXPR = 3'd4;

  logic        active_r, active_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic [1:0]  fn_r, fn_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [6:0]  shift_r, shift_nxt;
  logic [7:0]  bc_r, bc_nxt;
  logic [63:0] base_r, base_nxt;
  logic [63:0] ps_r, ps_nxt;
  logic [63:0] pe_r, pe_nxt;
  logic [5:0]  plen_r, plen_nxt;
  logic        lk_pend_r, lk_pend_nxt;
  logic        lk_oob_r, lk_oob_nxt;
  logic        lk_last_r, lk_last_nxt;

  logic [63:0] table_mem [ADDR_ENTRIES];
  logic [63:0] rd_r;
  logic [63:0] lk_val;

  logic              take;
  logic [7:0]        b;
  logic [7:0]        bc_inc;
  logic              fd, sf, rec, proceed, lastf, need_lk, is_len;
  logic [63:0]       fv;
  logic              tbl_we;

  function automatic logic is_addr(input logic [3:0] k, input logic [1:0] f);
    is_addr = ((f == 2'd0) && (k == EK_BASE_ADDR || k == EK_START_END ||
                               k == EK_START_LENGTH)) ||
              ((f == 2'd1) && (k == EK_START_END));
  endfunction

  assign in_ready = !lk_pend_r && !q_full &&
                    !(active_r && phase_r == PH_EXPR && !back_quiet);
  assign take     = in_valid && in_ready;
  assign b        = in_item.data_byte;
  assign bc_inc   = bc_r + 8'd1;
  assign lk_pend  = lk_pend_r;
  assign tbl_we   = take && in_item.action == ACT_LOAD;

  // Looked-up address: zero when out of range, masked to 32 bits for 4-byte addresses
  always_comb begin
    if (lk_oob_r) begin
      lk_val = '0;
    end else if (cfg.address_bytes == 8'd4) begin
      lk_val = {32'd0, rd_r[31:0]};
    end else begin
      lk_val = rd_r;
    end
  end

  // Parsing step
  always_comb begin
    active_nxt  = active_r;
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    fn_nxt      = fn_r;
    acc_nxt     = acc_r;
    shift_nxt   = shift_r;
    bc_nxt      = bc_r;
    base_nxt    = base_r;
    ps_nxt      = ps_r;
    pe_nxt      = pe_r;
    plen_nxt    = plen_r;
    lk_pend_nxt = 1'b0;
    lk_oob_nxt  = lk_oob_r;
    lk_last_nxt = lk_last_r;
    job         = '0;
    bw          = '0;
    fd          = 1'b0;
    sf          = 1'b0;
    rec         = 1'b0;
    proceed     = 1'b0;
    lastf       = 1'b0;
    need_lk     = 1'b0;
    is_len      = 1'b0;
    fv          = acc_r;

    if (lk_pend_r) begin
      // second half of an indexed field
      fd      = 1'b1;
      fv      = lk_val;
      lastf   = lk_last_r;
      proceed = 1'b1;
    end else if (take) begin
      unique case (in_item.action)
        ACT_START: begin
          active_nxt = 1'b1;
          phase_nxt  = PH_CODE;
          kind_nxt   = '0;
          fn_nxt     = '0;
          acc_nxt    = '0;
          shift_nxt  = '0;
          bc_nxt     = '0;
          ps_nxt     = '0;
          pe_nxt     = '0;
          plen_nxt   = '0;
          base_nxt   = cfg.initial_base;
        end
        ACT_BYTE: begin
          if (active_r) begin
            proceed = 1'b1;
            lastf   = in_item.section_last;
            unique case (phase_r)
              PH_CODE: begin
                if (b == 8'd0) begin
                  job.tail_valid = 1'b1;
                  job.tail_kind  = RK_END;
                  active_nxt     = 1'b0;
                end else if (b > 8'd8 || (b >= 8'd6 && cfg.address_bytes != 8'd4 &&
                                          cfg.address_bytes != 8'd8)) begin
                  job.tail_valid = 1'b1;
                  job.tail_kind  = RK_ERR;
                  active_nxt     = 1'b0;
                end else begin
                  kind_nxt = b[3:0];
                  fn_nxt   = '0;
                  plen_nxt = '0;
                  ps_nxt   = '0;
                  pe_nxt   = (b[3:0] == EK_DEFAULT_LOC) ? '1 : '0;
                  sf       = 1'b1;
                end
              end
              PH_LEB: begin
                if (shift_r < 7'd64) begin
                  acc_nxt   = acc_r | ({57'd0, b[6:0]} << shift_r[5:0]);
                  shift_nxt = shift_r + 7'd7;
                end
                if (!b[7]) begin
                  fd = 1'b1;
                  fv = acc_nxt;
                end
              end
              PH_SEL: begin
                bc_nxt = bc_inc;
                if (bc_inc >= cfg.selector_bytes) begin
                  bc_nxt    = '0;
                  phase_nxt = PH_ADDR;
                end
              end
              PH_ADDR: begin
                acc_nxt = acc_r | ({56'd0, b} << {bc_r[2:0], 3'b000});
                bc_nxt  = bc_inc;
                if (bc_inc >= cfg.address_bytes || bc_inc >= 8'd8) begin
                  fd = 1'b1;
                  fv = acc_nxt;
                end
              end
              PH_EXPR: begin
                if (bc_r < 8'(EXPR_BYTES)) begin
                  bw.en   = 1'b1;
                  bw.addr = bc_r[EXPR_AW-1:0];
                  bw.data = b;
                end
                bc_nxt = bc_inc;
                if (bc_inc >= {2'b00, plen_r}) begin
                  rec = 1'b1;
                end
              end
              default: begin
                phase_nxt = PH_CODE;
              end
            endcase
          end
        end
        default: begin
          // loads are written below; other actions are ignored
        end
      endcase
    end

    // Completed field
    if (fd) begin
      need_lk = !lk_pend_r && ((kind_r == EK_BASE_ADDRX) ||
                ((kind_r == EK_STARTX_ENDX || kind_r == EK_STARTX_LENGTH) &&
                 fn_r == 2'd0) ||
                (kind_r == EK_STARTX_ENDX && fn_r == 2'd1));
      is_len  = (kind_r == EK_DEFAULT_LOC) ? (fn_r == 2'd0) : (fn_r == 2'd2);
      if (need_lk) begin
        lk_pend_nxt = 1'b1;
        lk_oob_nxt  = (fv >= {55'd0, cfg.table_count}) || (fv >= 64'(ADDR_ENTRIES));
        lk_last_nxt = lastf;
        proceed     = 1'b0;
      end else if (kind_r == EK_BASE_ADDRX || kind_r == EK_BASE_ADDR) begin
        base_nxt = fv;
        ps_nxt   = fv;
        pe_nxt   = fv;
        plen_nxt = '0;
        rec      = 1'b1;
      end else if (is_len) begin
        if (fv > 64'(EXPR_BYTES)) begin
          active_nxt     = 1'b0;
          phase_nxt      = PH_CODE;
          job.tail_valid = 1'b1;
          job.tail_kind  = RK_ERR;
        end else begin
          plen_nxt = fv[5:0];
          if (fv == '0) begin
            rec = 1'b1;
          end else begin
            bc_nxt    = '0;
            phase_nxt = PH_EXPR;
          end
        end
      end else begin
        if (fn_r == 2'd0) begin
          ps_nxt = (kind_r == EK_OFFSET_PAIR) ? base_r + fv : fv;
        end else if (kind_r == EK_STARTX_LENGTH || kind_r == EK_START_LENGTH) begin
          pe_nxt = ps_r + fv;
        end else if (kind_r == EK_OFFSET_PAIR) begin
          pe_nxt = base_r + fv;
        end else begin
          pe_nxt = fv;
        end
        fn_nxt = fn_r + 2'd1;
        sf     = 1'b1;
      end
    end

    // Start of the next field
    if (sf) begin
      acc_nxt   = '0;
      shift_nxt = '0;
      bc_nxt    = '0;
      if (is_addr(kind_nxt, fn_nxt)) begin
        phase_nxt = (cfg.selector_bytes != 8'd0) ? PH_SEL : PH_ADDR;
      end else begin
        phase_nxt = PH_LEB;
      end
    end

    // Completed entry record
    if (rec) begin
      job.has_rec     = 1'b1;
      job.entry_kind  = kind_r;
      job.range_start = ps_nxt;
      job.range_end   = pe_nxt;
      job.is_default  = (kind_r == EK_DEFAULT_LOC);
      job.expr_length = plen_nxt;
      phase_nxt       = PH_CODE;
    end

    // Section end
    if (proceed && active_nxt && lastf) begin
      job.tail_valid = 1'b1;
      if (phase_nxt == PH_CODE) begin
        job.tail_valid = !(rec && plen_nxt == 6'(EXPR_BYTES));
        job.tail_kind  = RK_SECT;
      end else begin
        job.tail_kind  = RK_TRUNC;
      end
      active_nxt = 1'b0;
      phase_nxt  = PH_CODE;
    end

    push = job.has_rec || job.tail_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      phase_r   <= PH_CODE;
      kind_r    <= '0;
      fn_r      <= '0;
      acc_r     <= '0;
      shift_r   <= '0;
      bc_r      <= '0;
      base_r    <= '0;
      ps_r      <= '0;
      pe_r      <= '0;
      plen_r    <= '0;
      lk_pend_r <= 1'b0;
      lk_oob_r  <= 1'b0;
      lk_last_r <= 1'b0;
    end else begin
      active_r  <= active_nxt;
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      fn_r      <= fn_nxt;
      acc_r     <= acc_nxt;
      shift_r   <= shift_nxt;
      bc_r      <= bc_nxt;
      base_r    <= base_nxt;
      ps_r      <= ps_nxt;
      pe_r      <= pe_nxt;
      plen_r    <= plen_nxt;
      lk_pend_r <= lk_pend_nxt;
      lk_oob_r  <= lk_oob_nxt;
      lk_last_r <= lk_last_nxt;
    end
  end

  // Address table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      table_mem[in_item.table_index[ADDR_AW-1:0]] <= in_item.table_value;
    end
    rd_r <= table_mem[fv[ADDR_AW-1:0]];
  end

endmodule

### design/lle_back.sv
// Result back end: replays each job as an optional record with its expression
// bytes and an optional closing result. Holds the expression buffer. Depends on lle_pkg.
module lle_back import lle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  bw_t       bw,
  input  logic      q_empty,
  input  job_t      q_data,
  output logic      pop,
  output logic      busy,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_REC   = 2'd1;
  localparam logic [1:0] B_BYTES = 2'd2;
  localparam logic [1:0] B_TAIL  = 2'd3;

  logic [1:0]  st_r, st_nxt;
  logic [5:0]  idx_r, idx_nxt;
  job_t        cur_r, cur_nxt;
  logic        ov_r, ov_nxt;
  out_item_t   out_r, out_nxt;
  logic        load_out, out_free;
  logic [7:0]  ebuf [EXPR_BYTES];
  logic [7:0]  rd_r;

  assign out_free  = !ov_r || !out_stall;
  assign busy      = (st_r != B_IDLE);
  assign out_valid = ov_r;
  assign out_item  = out_r;

  // Sequencer
  always_comb begin
    st_nxt   = st_r;
    idx_nxt  = idx_r;
    cur_nxt  = cur_r;
    pop      = 1'b0;
    load_out = 1'b0;
    out_nxt  = '0;
    if (out_free) begin
      unique case (st_r)
        B_IDLE: begin
          if (!q_empty) begin
            pop     = 1'b1;
            cur_nxt = q_data;
            st_nxt  = q_data.has_rec ? B_REC : B_TAIL;
          end
        end
        B_REC: begin
          load_out            = 1'b1;
          out_nxt.kind        = RK_ENTRY;
          out_nxt.entry_kind  = cur_r.entry_kind;
          out_nxt.range_start = cur_r.range_start;
          out_nxt.range_end   = cur_r.range_end;
          out_nxt.is_default  = cur_r.is_default;
          out_nxt.expr_length = cur_r.expr_length;
          out_nxt.run_last    = (cur_r.expr_length == '0) && !cur_r.tail_valid;
          idx_nxt             = '0;
          if (cur_r.expr_length != '0) begin
            st_nxt = B_BYTES;
          end else begin
            st_nxt = cur_r.tail_valid ? B_TAIL : B_IDLE;
          end
        end
        B_BYTES: begin
          load_out          = 1'b1;
          out_nxt.kind      = RK_EXPR;
          out_nxt.expr_byte = rd_r;
          idx_nxt           = idx_r + 6'd1;
          if (idx_nxt == cur_r.expr_length) begin
            out_nxt.run_last = !cur_r.tail_valid;
            st_nxt           = cur_r.tail_valid ? B_TAIL : B_IDLE;
          end
        end
        B_TAIL: begin
          load_out         = 1'b1;
          out_nxt.kind     = cur_r.tail_kind;
          out_nxt.run_last = 1'b1;
          st_nxt           = B_IDLE;
        end
        default: begin
          st_nxt = B_IDLE;
        end
      endcase
    end
    ov_nxt = load_out ? 1'b1 : (out_stall ? ov_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_IDLE;
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  // Expression buffer: read one byte ahead of the sequencer
  always_ff @(posedge clk) begin
    if (bw.en) begin
      ebuf[bw.addr] <= bw.data;
    end
    rd_r <= ebuf[idx_nxt[EXPR_AW-1:0]];
  end

endmodule

### design/location_list_entry_parser.sv
// Location list entry parser, top level.
// Input channel (in_valid/in_stall/in_item): one item per accept, either a
// start-of-list, a list byte or an address table load. Output channel
// (out_valid/out_stall/out_item): entry records, expression bytes and the
// end-of-list, section end, truncated and error results; run_last marks the
// last result caused by one item.
// The front decodes one byte per cycle while in_stall is low; indexed fields
// (address table lookups) hold in_stall for the registered table read.
// Completed entries go through a two-job queue to the back end, which sends
// one result per cycle while out_stall is low, after an idle state that
// picks up each job. While the front is collecting expression bytes it waits
// until the back end has drained, as both share the expression buffer.
// A result is registered in the queue slot, the back end's job register and
// its output register in turn.
// Reset (rst_n low, synchronous) clears the parser, queue and output valid;
// configuration returns to base 0, 8-byte addresses, no selector, empty table.
// When out_stall is high the output register holds; the queue fills and then
// in_stall rises. Configuration is written through cfg_we/cfg_index/cfg_wdata.
module location_list_entry_parser import lle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;
  logic in_ready, push, pop, q_full, q_empty, back_busy, back_quiet, lk_pend;
  job_t push_job, q_data;
  bw_t  bw;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE:   cfg_nxt.initial_base   = cfg_wdata;
        REG_ABYTES: cfg_nxt.address_bytes  = cfg_wdata[7:0];
        REG_SBYTES: cfg_nxt.selector_bytes = cfg_wdata[7:0];
        REG_TCOUNT: cfg_nxt.table_count    = cfg_wdata[8:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_base   <= '0;
      cfg_r.address_bytes  <= 8'd8;
      cfg_r.selector_bytes <= '0;
      cfg_r.table_count    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall   = !in_ready;
  assign back_quiet = q_empty && !back_busy;

  lle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .q_full     (q_full),
    .back_quiet (back_quiet),
    .push       (push),
    .job        (push_job),
    .bw         (bw),
    .lk_pend    (lk_pend)
  );

  lle_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_job),
    .pop   (pop),
    .dout  (q_data),
    .full  (q_full),
    .empty (q_empty)
  );

  lle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .bw        (bw),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .pop       (pop),
    .busy      (back_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Checks
  a_lookup_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    lk_pend |-> in_stall)
    else $error("input taken during table lookup");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && q_full) |-> pop)
    else $error("job queue overflow");

  a_buf_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    bw.en |-> back_quiet)
    else $error("expression buffer written during replay");

  a_default_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.kind == RK_ENTRY && out_item.is_default) |->
      (out_item.entry_kind == EK_DEFAULT_LOC))
    else $error("default flag on wrong entry kind");

endmodule
